/* design/cmpt_pkg.sv */
// Shared types and constants for the counting minimum priority table.
package cmpt_pkg;

  localparam int CAPACITY   = 64;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int KEY_W      = 32;
  localparam int OUT_CNT_W  = 16;
  localparam int ENTRY_W    = KEY_W + COUNT_BITS;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_LOOKUP  = 2'd1,
    MODE_DELETE  = 2'd2,
    MODE_DEL_MIN = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_NEW       = 3'd0,
    ST_INC       = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_DEC       = 3'd5,
    ST_EMPTY     = 3'd6,
    ST_FULL      = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_FINISH = 2'd2
  } state_e;

endpackage

/* design/counting_min_priority_table_top.sv */
// Counting min priority table: one slot scanned per cycle through a registered memory port.
// Per item: each slot is read, the registered read is compared, then the update and result follow.
// Items are accepted only in S_IDLE; the single read port of the slot memory paces the scan.
// The next item is accepted while a finished result still waits in the output register.
// Reset (rst_ni low, async) empties the table (all slot valid bits clear) and drops any result.
module counting_min_priority_table_top
  import cmpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] key
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [31:0] key_out, [47:32] count
  output logic [2:0]  m_axis_tuser_o    // [2:0] status
);

  localparam logic [IDX_W:0]        CNT_END  = (IDX_W + 1)'(CAPACITY);
  localparam logic [IDX_W:0]        CNT_STEP = (IDX_W + 1)'(1);
  localparam logic [IDX_W-1:0]      IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX  = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE  = COUNT_BITS'(1);

  state_e state_q, state_d;
  mode_e  mode_q;
  logic signed [KEY_W-1:0] key_q;

  logic [ENTRY_W-1:0]  mem_q [CAPACITY];
  logic [ENTRY_W-1:0]  rd_q;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;

  logic [CAPACITY-1:0] valid_q;
  logic                valid_set, valid_clr;
  logic [IDX_W-1:0]    valid_idx;

  logic [IDX_W:0]      cnt_q;
  logic                issue;
  logic                p_q, p_sv_q;
  logic [IDX_W-1:0]    p_idx_q;

  logic                    hit_q, free_q;
  logic [IDX_W-1:0]        hit_idx_q, free_idx_q;
  logic signed [KEY_W-1:0] hit_key_q;
  logic [COUNT_BITS-1:0]   hit_cnt_q;

  logic signed [KEY_W-1:0] e_key;
  logic [COUNT_BITS-1:0]   e_cnt;
  logic                    take, take_free;

  logic                    out_valid_q;
  status_e                 out_status_q, res_status;
  logic signed [KEY_W-1:0] out_key_q, res_key;
  logic [OUT_CNT_W-1:0]    out_cnt_q;
  logic [COUNT_BITS-1:0]   res_cnt;
  logic [31:0]             res_cnt_ext;
  logic                    accept, fire;

  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign issue  = (state_q == S_SCAN) && (cnt_q < CNT_END);

  // compare stage on registered read data
  assign e_key = rd_q[KEY_W-1:0];
  assign e_cnt = rd_q[ENTRY_W-1:KEY_W];
  always_comb begin
    if (mode_q == MODE_DEL_MIN) begin
      take = p_q && p_sv_q && (!hit_q || (e_key < hit_key_q));
    end else begin
      take = p_q && p_sv_q && (e_key == key_q);
    end
    take_free = p_q && !p_sv_q && !free_q;
  end

  // sequencer and result logic
  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    fire            = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = hit_idx_q;
    mem_wdata       = {hit_cnt_q, hit_key_q};
    valid_set       = 1'b0;
    valid_clr       = 1'b0;
    valid_idx       = hit_idx_q;
    res_status      = ST_NOT_FOUND;
    res_key         = key_q;
    res_cnt         = '0;

    unique case (mode_q)
      MODE_INSERT: begin
        if (hit_q) begin
          res_status = ST_INC;
          res_cnt    = (hit_cnt_q == CNT_MAX) ? hit_cnt_q : hit_cnt_q + CNT_ONE;
          mem_wdata  = {res_cnt, key_q};
        end else if (free_q) begin
          res_status = ST_NEW;
          res_cnt    = CNT_ONE;
          mem_waddr  = free_idx_q;
          valid_idx  = free_idx_q;
          mem_wdata  = {CNT_ONE, key_q};
        end else begin
          res_status = ST_FULL;
        end
      end
      MODE_LOOKUP: begin
        if (hit_q) begin
          res_status = ST_FOUND;
          res_cnt    = hit_cnt_q;
        end
      end
      MODE_DELETE, MODE_DEL_MIN: begin
        if (hit_q) begin
          res_key = hit_key_q;
          if (hit_cnt_q <= CNT_ONE) begin
            res_status = ST_REMOVED;
          end else begin
            res_status = ST_DEC;
            res_cnt    = hit_cnt_q - CNT_ONE;
            mem_wdata  = {res_cnt, hit_key_q};
          end
        end else if (mode_q == MODE_DEL_MIN) begin
          res_status = ST_EMPTY;
          res_key    = '0;
        end
      end
      default: ;
    endcase

    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (p_q && (p_idx_q == IDX_LAST)) state_d = S_FINISH;
      end
      S_FINISH: begin
        fire = !out_valid_q || m_axis_tready_i;
        if (fire) begin
          state_d = S_IDLE;
          unique case (res_status)
            ST_NEW: begin
              mem_we    = 1'b1;
              valid_set = 1'b1;
            end
            ST_INC, ST_DEC: mem_we = 1'b1;
            ST_REMOVED:     valid_clr = 1'b1;
            default: ;
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign res_cnt_ext = 32'(res_cnt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      p_q         <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      p_q     <= issue;
      if (accept) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (issue) cnt_q <= cnt_q + CNT_STEP;
        if (take) hit_q <= 1'b1;
        if (take_free) free_q <= 1'b1;
      end
      if (valid_set) valid_q[valid_idx] <= 1'b1;
      if (valid_clr) valid_q[valid_idx] <= 1'b0;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_e'(s_axis_tuser_i);
      key_q  <= s_axis_tdata_i;
    end
    p_idx_q <= cnt_q[IDX_W-1:0];
    p_sv_q  <= valid_q[cnt_q[IDX_W-1:0]];
    if (take) begin
      hit_idx_q <= p_idx_q;
      hit_key_q <= e_key;
      hit_cnt_q <= e_cnt;
    end
    if (take_free) free_idx_q <= p_idx_q;
    if (fire) begin
      out_status_q <= res_status;
      out_key_q    <= res_key;
      out_cnt_q    <= res_cnt_ext[OUT_CNT_W-1:0];
    end
  end

  // slot memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    rd_q <= mem_q[cnt_q[IDX_W-1:0]];
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_cnt_q, out_key_q};
  assign m_axis_tuser_o  = out_status_q;

endmodule

/* bench/cmpt_reply_checker.sv */
// Reply checker for the counting min priority table: tracks the table contents and checks every reply.
module cmpt_reply_checker
  import cmpt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] key
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] mode
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [47:0] m_axis_tdata_i,   // [31:0] key_out, [47:32] count
  input  logic [2:0]  m_axis_tuser_i,   // [2:0] status
  output int          fail_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    status_e                status;
    logic [KEY_W-1:0]       key;
    logic [OUT_CNT_W-1:0]   count;
  } table_reply_t;

  localparam logic [COUNT_BITS-1:0] CNT_TOP  = '1;
  localparam logic [COUNT_BITS-1:0] CNT_UNIT = COUNT_BITS'(1);

  // shadow copy of the table
  logic [KEY_W-1:0]      slot_key  [CAPACITY];
  logic [COUNT_BITS-1:0] slot_cnt  [CAPACITY];
  logic                  slot_live [CAPACITY];

  table_reply_t replies_due[$];
  int           fail_n = 0;

  function automatic int find_key(input logic [KEY_W-1:0] k);
    for (int s = 0; s < CAPACITY; s++)
      if (slot_live[s] && slot_key[s] == k) return s;
    return -1;
  endfunction

  function automatic int free_slot();
    for (int s = 0; s < CAPACITY; s++)
      if (!slot_live[s]) return s;
    return -1;
  endfunction

  // remove one copy from a live slot, freeing it when the count runs out
  task automatic take_one(input int s, inout table_reply_t r);
    r.key = slot_key[s];
    if (slot_cnt[s] <= CNT_UNIT) begin
      slot_cnt[s]  = '0;
      slot_live[s] = 1'b0;
      r.status     = ST_REMOVED;
      r.count      = '0;
    end else begin
      slot_cnt[s] = slot_cnt[s] - CNT_UNIT;
      r.status    = ST_DEC;
      r.count     = OUT_CNT_W'(slot_cnt[s]);
    end
  endtask

  task automatic predict_reply(input mode_e op, input logic [KEY_W-1:0] k,
                               output table_reply_t r);
    int s;
    int best;
    r.status = ST_NOT_FOUND;
    r.key    = k;
    r.count  = '0;
    case (op)
      MODE_INSERT: begin
        s = find_key(k);
        if (s >= 0) begin
          if (slot_cnt[s] != CNT_TOP) slot_cnt[s] = slot_cnt[s] + CNT_UNIT;
          r.status = ST_INC;
          r.count  = OUT_CNT_W'(slot_cnt[s]);
        end else begin
          s = free_slot();
          if (s < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_live[s] = 1'b1;
            slot_key[s]  = k;
            slot_cnt[s]  = CNT_UNIT;
            r.status     = ST_NEW;
            r.count      = OUT_CNT_W'(1);
          end
        end
      end
      MODE_LOOKUP: begin
        s = find_key(k);
        if (s >= 0) begin
          r.status = ST_FOUND;
          r.count  = OUT_CNT_W'(slot_cnt[s]);
        end
      end
      MODE_DELETE: begin
        s = find_key(k);
        if (s >= 0) take_one(s, r);
      end
      default: begin
        best = -1;
        for (int i = 0; i < CAPACITY; i++)
          if (slot_live[i] && (best < 0 || $signed(slot_key[i]) < $signed(slot_key[best])))
            best = i;
        if (best < 0) begin
          r.status = ST_EMPTY;
          r.key    = '0;
        end else begin
          take_one(best, r);
        end
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_reply_t got;
    table_reply_t want;
    if (!rst_ni) begin
      for (int s = 0; s < CAPACITY; s++) slot_live[s] = 1'b0;
      replies_due.delete();
    end else begin
      // replies first: a reply never belongs to an item taken on the same edge
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.status = status_e'(m_axis_tuser_i);
        got.key    = m_axis_tdata_i[31:0];
        got.count  = m_axis_tdata_i[47:32];
        if (replies_due.size() == 0) begin
          fail_n++;
          if (fail_n <= 10)
            $display("%0t: unexpected reply st=%0d key=%h cnt=%0d", $time,
                     got.status, got.key, got.count);
        end else begin
          want = replies_due.pop_front();
          if (got.status !== want.status || got.key !== want.key ||
              got.count !== want.count) begin
            fail_n++;
            if (fail_n <= 10)
              $display("%0t: reply mismatch want st=%0d key=%h cnt=%0d, got st=%0d key=%h cnt=%0d",
                       $time, want.status, want.key, want.count,
                       got.status, got.key, got.count);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        predict_reply(mode_e'(s_axis_tuser_i), s_axis_tdata_i, want);
        replies_due = {replies_due, want};
      end
    end
    fail_cnt_o <= fail_n;
    pending_o  <= replies_due.size();
  end

endmodule

/* bench/tb_counting_min_priority_table_top.sv */
// Testbench top for the counting min priority table: stimulus, flow control and verdict.
module tb_counting_min_priority_table_top
  import cmpt_pkg::*;
();

  typedef enum int {
    PH_FILL,
    PH_DRAIN,
    PH_MIX,
    PH_NOISE
  } phase_e;

  localparam int               STIM_ITEMS = 1250;
  localparam int               POOL_N     = CAPACITY + CAPACITY / 2;
  localparam logic [KEY_W-1:0] KEY_LO     = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_HI     = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] KEY_ZERO   = 32'h0000_0000;
  localparam logic [KEY_W-1:0] KEY_NEG1   = 32'hffff_ffff;
  localparam logic [KEY_W-1:0] KEY_ABSENT = 32'h0000_0005;
  localparam logic [KEY_W-1:0] KEY_TWICE  = 32'h0000_0007;
  localparam logic [KEY_W-1:0] KEY_SAT    = 32'h0000_5a5a;

  logic        clk      = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] key
  logic [1:0]  s_tuser  = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // [31:0] key_out, [47:32] count
  logic [2:0]  m_tuser;         // [2:0] status
  int          fail_cnt;
  int          pending;

  logic [KEY_W-1:0] key_pool [POOL_N];
  int               burst_left = 0;
  int               sent       = 0;
  int               stall_run  = 0;
  int               stall_kind = 0;

  counting_min_priority_table_top i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  cmpt_reply_checker i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .fail_cnt_o      (fail_cnt),
    .pending_o       (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: stretches of always-ready, coin-flip and mostly-stalled
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run  <= $urandom_range(8, 64);
      stall_kind <= $urandom_range(0, 2);
      m_tready   <= 1'b1;
    end else begin
      stall_run <= stall_run - 1;
      case (stall_kind)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= $urandom_range(0, 1);
        end
        default: begin
          m_tready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  // called at the edge of the previous accept, so tvalid can stay high in a burst
  task automatic send_item(input mode_e op, input logic [KEY_W-1:0] k);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= k;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  // hold off until every reply is back
  task automatic drain_wait();
    s_tvalid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_N - 1)];
    return $urandom;
  endfunction

  task automatic run_phase(input phase_e kind, input int len);
    int    cut_ins;
    int    cut_look;
    int    cut_del;
    int    roll;
    mode_e op;
    case (kind)
      PH_FILL: begin
        cut_ins = 80; cut_look = 90; cut_del = 95;
      end
      PH_DRAIN: begin
        cut_ins = 5; cut_look = 15; cut_del = 45;
      end
      default: begin
        cut_ins = 25; cut_look = 50; cut_del = 75;
      end
    endcase
    for (int n = 0; n < len && sent < STIM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < cut_ins)       op = MODE_INSERT;
      else if (roll < cut_look) op = MODE_LOOKUP;
      else if (roll < cut_del)  op = MODE_DELETE;
      else                      op = MODE_DEL_MIN;
      send_item(op, (kind == PH_NOISE) ? $urandom : pick_key());
    end
  endtask

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    key_pool[0] = KEY_LO;
    key_pool[1] = KEY_HI;
    key_pool[2] = KEY_ZERO;
    key_pool[3] = KEY_NEG1;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, every mode, absent keys, repeat counts, min order, empty table
    send_item(MODE_INSERT, KEY_LO);
    send_item(MODE_INSERT, KEY_HI);
    send_item(MODE_INSERT, KEY_ZERO);
    send_item(MODE_INSERT, KEY_NEG1);
    send_item(MODE_INSERT, KEY_HI);
    send_item(MODE_LOOKUP, KEY_HI);
    send_item(MODE_LOOKUP, KEY_ABSENT);
    send_item(MODE_DELETE, KEY_ABSENT);
    send_item(MODE_DELETE, KEY_HI);
    send_item(MODE_DELETE, KEY_HI);
    send_item(MODE_LOOKUP, KEY_HI);
    send_item(MODE_INSERT, KEY_TWICE);
    send_item(MODE_INSERT, KEY_TWICE);
    send_item(MODE_DEL_MIN, KEY_NEG1);   // key is don't-care here
    send_item(MODE_DEL_MIN, $urandom);
    send_item(MODE_DEL_MIN, KEY_HI);
    send_item(MODE_DEL_MIN, KEY_ZERO);
    send_item(MODE_DEL_MIN, KEY_LO);
    send_item(MODE_DEL_MIN, $urandom);
    send_item(MODE_LOOKUP, KEY_ZERO);
    send_item(MODE_DELETE, KEY_NEG1);
    drain_wait();

    // count saturation only when the count width keeps it short
    if (COUNT_BITS <= 10) begin
      repeat ((1 << COUNT_BITS) + 1) send_item(MODE_INSERT, KEY_SAT);
      send_item(MODE_LOOKUP, KEY_SAT);
    end

    // fill every slot, then one more distinct key to hit the full table
    for (int i = 0; i <= CAPACITY; i++) send_item(MODE_INSERT, key_pool[i]);

    while (sent < STIM_ITEMS) begin
      run_phase(phase_e'($urandom_range(0, 3)), $urandom_range(40, 160));
      if ($urandom_range(0, 3) == 0) drain_wait();
    end
    drain_wait();
    repeat (2 * CAPACITY + 20) @(posedge clk);

    if (fail_cnt == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
